// ===== rtl/core/ult_pkg.sv =====
package ult_pkg;

   localparam int DEPTH    = 128;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 8;
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QFILL_W  = $clog2(QDEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_DELETE = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      action_type         action;
      logic               scan;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] new_value;
   } cmd_type;

endpackage

// ===== rtl/core/ult_ram.sv =====
module ult_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ult_front.sv =====
module ult_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ult_pkg::ACTION_W-1:0]      req_action,
   input  logic signed [ult_pkg::VALUE_W-1:0] req_value,
   input  logic signed [ult_pkg::VALUE_W-1:0] req_new_value,
   output logic                              q_valid,
   output ult_pkg::cmd_type                  q_cmd,
   input  logic                              q_pop
);
   import ult_pkg::*;

   cmd_type              slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;
   logic                 push;
   cmd_type              cmd_new;

   // classify the incoming transfer
   always_comb begin
      cmd_new.action    = action_type'(req_action);
      cmd_new.scan      = (action_type'(req_action) != ACT_INSERT);
      cmd_new.value     = $unsigned(req_value);
      cmd_new.new_value = $unsigned(req_new_value);
   end

   assign req_stall = (fill_ff == QFILL_W'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (fill_ff != '0))
      else $error("queue popped while empty");

endmodule

// ===== rtl/core/ult_back.sv =====
module ult_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  ult_pkg::cmd_type              q_cmd,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ult_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ult_pkg::POS_W-1:0]     rsp_position,
   output logic [ult_pkg::COUNT_W-1:0]   rsp_count
);
   import ult_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     addr_ff, addr_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pidx_ff, pidx_in;
   status_type           res_status_ff, res_status_in;
   logic [ADDR_W-1:0]    res_pos_ff, res_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [VALUE_W-1:0]   ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [VALUE_W-1:0]   ram_rdata;
   logic [CNT_W-1:0]     addr_dec;

   ult_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign addr_dec = addr_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;
      q_pop         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (!q_cmd.scan) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     res_status_in = ST_FULL;
                     res_pos_in    = '0;
                  end else begin
                     ram_we        = 1'b1;
                     ram_waddr     = count_ff[ADDR_W-1:0];
                     ram_wdata     = q_cmd.value;
                     count_in      = count_ff + 1'b1;
                     res_status_in = ST_OK;
                     res_pos_in    = count_ff[ADDR_W-1:0];
                  end
                  state_in = S_RESP;
               end else begin
                  addr_in  = '0;
                  pend_in  = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read one entry a cycle, compare the one returned last cycle
            if (pend_ff && (ram_rdata == cmd_ff.value)) begin
               res_status_in = ST_OK;
               res_pos_in    = pidx_ff;
               pend_in       = 1'b0;
               if (cmd_ff.action == ACT_UPDATE) begin
                  ram_we    = 1'b1;
                  ram_waddr = pidx_ff;
                  ram_wdata = cmd_ff.new_value;
                  state_in  = S_RESP;
               end else if (cmd_ff.action == ACT_DELETE) begin
                  addr_in  = CNT_W'(pidx_ff) + 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_RESP;
               end
            end else if (addr_ff < count_ff) begin
               ram_raddr = addr_ff[ADDR_W-1:0];
               pend_in   = 1'b1;
               pidx_in   = addr_ff[ADDR_W-1:0];
               addr_in   = addr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  res_status_in = ST_NOT_FOUND;
                  res_pos_in    = '0;
                  state_in      = S_RESP;
               end
            end
         end
         S_SHIFT: begin
            // move each later entry down one place
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pidx_ff;
               ram_wdata = ram_rdata;
            end
            if (addr_ff < count_ff) begin
               ram_raddr = addr_ff[ADDR_W-1:0];
               pend_in   = 1'b1;
               pidx_in   = addr_dec[ADDR_W-1:0];
               addr_in   = addr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = POS_W'(res_pos_ff);
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      pidx_ff       <= pidx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_count    = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SHIFT) |-> addr_ff <= count_ff)
      else $error("scan address past entry count");

   a_no_write_in_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> !ram_we)
      else $error("store written while result pending");

   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE))
      else $error("command taken while busy");

endmodule

// ===== rtl/core/unsorted_list_table.sv =====
// channel   | valid      | stall      | payload
// request   | req_valid  | req_stall  | req_action, req_value, req_new_value
// response  | rsp_valid  | rsp_stall  | rsp_status, rsp_position, rsp_count
//
// one request at a time; an insert writes the store directly, while search, update
// and delete scan the list reading one store entry per cycle, and delete then shifts
// each later entry down one place
// a 2-entry queue takes requests while the back end works
// reset clears the count and the queue; the store is not cleared
// a stalled response holds and the next result waits behind it
module unsorted_list_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ult_pkg::ACTION_W-1:0]      req_action,
   input  logic signed [ult_pkg::VALUE_W-1:0] req_value,
   input  logic signed [ult_pkg::VALUE_W-1:0] req_new_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ult_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ult_pkg::POS_W-1:0]         rsp_position,
   output logic [ult_pkg::COUNT_W-1:0]       rsp_count
);
   import ult_pkg::*;

   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;

   ult_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_value     (req_value),
      .req_new_value (req_new_value),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop)
   );

   ult_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

endmodule

// ===== tb/sv/list_table_checker.sv =====
`timescale 1ns / 1ps

module list_table_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [ult_pkg::ACTION_W-1:0] req_action,
   input  logic [ult_pkg::VALUE_W-1:0]  req_value,
   input  logic [ult_pkg::VALUE_W-1:0]  req_new_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [ult_pkg::STATUS_W-1:0] rsp_status,
   input  logic [ult_pkg::POS_W-1:0]    rsp_position,
   input  logic [ult_pkg::COUNT_W-1:0]  rsp_count,
   output int                           fail_count,
   output int                           pending
);
   import ult_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   logic [VALUE_W-1:0] shadow_list [DEPTH];
   int                 shadow_fill;
   outcome_type        outcome_q [$];
   int                 report_count;
   int                 action_seen [4];
   int                 full_seen;
   int                 miss_seen;
   int                 peak_fill;

   function automatic outcome_type apply_request(action_type act, logic [VALUE_W-1:0] key,
                                                 logic [VALUE_W-1:0] repl);
      outcome_type o;
      int          hit;
      o.status   = ST_OK;
      o.position = '0;
      hit        = -1;
      if (act == ACT_INSERT) begin
         if (shadow_fill >= DEPTH) begin
            o.status = ST_FULL;
         end else begin
            o.position               = POS_W'(shadow_fill);
            shadow_list[shadow_fill] = key;
            shadow_fill++;
         end
      end else begin
         for (int i = 0; i < shadow_fill; i++) begin
            if (hit < 0 && shadow_list[i] == key) hit = i;
         end
         if (hit < 0) begin
            o.status = ST_NOT_FOUND;
         end else begin
            o.position = POS_W'(hit);
            if (act == ACT_UPDATE) begin
               shadow_list[hit] = repl;
            end else if (act == ACT_DELETE) begin
               // close the gap so the list stays compact
               for (int i = hit; i + 1 < shadow_fill; i++) shadow_list[i] = shadow_list[i + 1];
               shadow_fill--;
            end
         end
      end
      o.count = COUNT_W'(shadow_fill);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         shadow_fill = 0;
         outcome_q.delete();
      end else begin
         // response side first: a transfer can never answer a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            got.status   = status_type'(rsp_status);
            got.position = rsp_position;
            got.count    = rsp_count;
            if (outcome_q.size() == 0) begin
               fail_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("%0t: unexpected response status %0d position %0d count %0d",
                           $realtime, rsp_status, rsp_position, rsp_count);
               end
            end else begin
               want = outcome_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (report_count < 10) begin
                     report_count++;
                     $display("%0t: response mismatch, expected status %0d position %0d count %0d",
                              $realtime, want.status, want.position, want.count);
                     $display("%0t:                    actual status %0d position %0d count %0d",
                              $realtime, rsp_status, rsp_position, rsp_count);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_request(action_type'(req_action), req_value, req_new_value);
            outcome_q.push_back(want);
            action_seen[req_action]++;
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_NOT_FOUND) miss_seen++;
            if (shadow_fill > peak_fill) peak_fill = shadow_fill;
         end
      end
      pending = outcome_q.size();
   end

   task print_summary();
      $display("covered %0d inserts, %0d searches, %0d updates and %0d deletes",
               action_seen[ACT_INSERT], action_seen[ACT_SEARCH], action_seen[ACT_UPDATE],
               action_seen[ACT_DELETE]);
      $display("%0d inserts refused on a full list, %0d lookups missed, list peaked at %0d of %0d",
               full_seen, miss_seen, peak_fill, DEPTH);
   endtask

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ult_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int QUIET_FROM   = 1100;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 300;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [ACTION_W-1:0]        req_action;
   logic signed [VALUE_W-1:0]  req_value;
   logic signed [VALUE_W-1:0]  req_new_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [STATUS_W-1:0]        rsp_status;
   logic [POS_W-1:0]           rsp_position;
   logic [COUNT_W-1:0]         rsp_count;
   int                         fail_count;
   int                         pending;
   logic                       quiet_tail;
   logic [VALUE_W-1:0]         value_pool [16];
   logic [VALUE_W-1:0]         stray_values [$];

   unsorted_list_table dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_value     (req_value),
      .req_new_value (req_new_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_count     (rsp_count)
   );

   list_table_checker table_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_value     (req_value),
      .req_new_value (req_new_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_count     (rsp_count),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #16_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_item(action_type act, logic [VALUE_W-1:0] v, logic [VALUE_W-1:0] nv);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_action    <= act;
      req_value     <= v;
      req_new_value <= nv;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic idle_gap(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return value_pool[$urandom_range(0, 15)];
      if (roll < 85 && stray_values.size() > 0)
         return stray_values[$urandom_range(0, stray_values.size() - 1)];
      return $urandom();
   endfunction

   // receiver side: short stall bursts, quiet stretches, and two long hold-offs
   initial begin : rsp_side
      int free_left;
      int stall_left;
      int cycle_no;
      rsp_stall  = 1'b0;
      free_left  = 0;
      stall_left = 0;
      cycle_no   = 0;
      forever begin
         @(negedge clock);
         cycle_no++;
         if (cycle_no == 2500 || cycle_no == 20000) stall_left = LONG_HOLD;
         if (quiet_tail) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
               free_left = $urandom_range(50, 200);
            end else begin
               free_left  = $urandom_range(0, 12);
               stall_left = $urandom_range(1, 9);
            end
         end
      end
   end

   initial begin : stimulus
      int          phase_pct [7];
      int          phase_len [7];
      int          done_random;
      bit          idle_on;
      action_type  act;
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] nv;

      phase_pct     = '{70, 92, 60, 10, 50, 90, 20};
      phase_len     = '{150, 180, 150, 200, 150, 180, 240};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_INSERT;
      req_value     = '0;
      req_new_value = '0;
      quiet_tail    = 1'b0;
      done_random   = 0;

      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'h0000_0001;
      value_pool[2] = 32'hFFFF_FFFF;
      value_pool[3] = 32'h0000_0002;
      value_pool[4] = 32'h8000_0000;
      value_pool[5] = 32'h7FFF_FFFF;
      value_pool[6] = 32'h5555_5555;
      value_pool[7] = 32'hAAAA_AAAA;
      for (int i = 8; i < 16; i++) value_pool[i] = $urandom();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: every lookup misses
      send_item(ACT_SEARCH, 32'h0000_0000, 32'h0000_0000);
      send_item(ACT_DELETE, 32'h0000_0005, 32'h0000_0000);
      send_item(ACT_UPDATE, 32'h0000_0005, 32'h1234_5678);
      // extremes and a duplicate
      send_item(ACT_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(ACT_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_item(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(ACT_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(ACT_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(ACT_SEARCH, 32'h7FFF_FFFE, 32'h0000_0000);
      send_item(ACT_SEARCH, 32'hFFFF_FFFE, 32'h0000_0000);
      // update hits only the lowest duplicate
      send_item(ACT_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(ACT_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(ACT_UPDATE, 32'h0000_0000, 32'h8000_0000);
      // delete at head and tail
      send_item(ACT_DELETE, 32'h8000_0000, 32'h0000_0000);
      send_item(ACT_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(ACT_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(ACT_INSERT, 32'h5555_5555, 32'h0000_0000);
      send_item(ACT_INSERT, 32'hAAAA_AAAA, 32'h0000_0000);
      send_item(ACT_DELETE, 32'hAAAA_AAAA, 32'h0000_0000);
      send_item(ACT_DELETE, 32'h8000_0000, 32'h0000_0000);
      send_item(ACT_DELETE, 32'h5555_5555, 32'h0000_0000);
      send_item(ACT_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);

      // phases swing the list between empty and full
      foreach (phase_len[p]) begin
         idle_on = $urandom_range(0, 2) != 0;
         for (int k = 0; k < phase_len[p]; k++) begin
            if (done_random >= QUIET_FROM) quiet_tail = 1'b1;
            if ($urandom_range(0, 99) < phase_pct[p]) begin
               act = ACT_INSERT;
               if ($urandom_range(0, 9) < 2) begin
                  v = $urandom();
                  stray_values.push_back(v);
                  if (stray_values.size() > 64) void'(stray_values.pop_front());
               end else begin
                  v = value_pool[$urandom_range(0, 15)];
               end
            end else begin
               act = action_type'($urandom_range(ACT_SEARCH, ACT_DELETE));
               v   = pick_key();
            end
            nv = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 15)] : $urandom();
            send_item(act, v, nv);
            done_random++;
            if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
               idle_gap($urandom_range(1, 9));
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      table_check.print_summary();
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ult_pkg.sv
rtl/core/ult_ram.sv
rtl/core/ult_front.sv
rtl/core/ult_back.sv
rtl/core/unsorted_list_table.sv
tb/sv/list_table_checker.sv
tb/sv/tb.sv
